// ===== sv/pptu_pkg.sv =====
// Shared constants, types and codes for the point projection / depth test unit.
// No dependencies; imported by the divider, sequencer, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none
package pptu_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int FAR_LIMIT     = 4096;

  localparam int PIXELS   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W   = $clog2(PIXELS);
  localparam int FAR_Q8   = FAR_LIMIT * 256;
  localparam int DEPTH_W  = $clog2(FAR_Q8 + 1);
  localparam int NEAR_Q8  = 13;
  localparam int DEN_W    = DEPTH_W + 6;
  localparam int HALF_W   = SCREEN_WIDTH / 2;
  localparam int HALF_H   = SCREEN_HEIGHT / 2;
  localparam int MAX_DIM  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QBITS    = $clog2(MAX_DIM);
  localparam int PIPE_CYC = 8;
  localparam int CNT_MAX  = (QBITS > PIPE_CYC) ? QBITS : PIPE_CYC;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_X    = 3'd0,
    CFG_CAMERA_Y    = 3'd1,
    CFG_CAMERA_Z    = 3'd2,
    CFG_YAW_COS     = 3'd3,
    CFG_YAW_SIN     = 3'd4,
    CFG_PITCH_COS   = 3'd5,
    CFG_PITCH_SIN   = 3'd6,
    CFG_FOCAL       = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_PIPE,
    ST_DIV,
    ST_RD,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic cap;
    logic div_load;
    logic div_step;
    logic ld_out;
    logic pix_we;
    logic clr_en;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic keep;
    logic div_ok;
    logic win;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/pptu_if.sv =====
// Valid/ready channel interfaces for point words and pixel-write words.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface pptu_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic        [31:0] point_color;
  logic signed [7:0]  normal_x;
  logic signed [7:0]  normal_y;
  logic signed [7:0]  normal_z;
  logic        [7:0]  spec_code;

  modport source (output valid, mode, point_x, point_y, point_z, point_color,
                  normal_x, normal_y, normal_z, spec_code, input ready);
  modport sink (input valid, mode, point_x, point_y, point_z, point_color,
                normal_x, normal_y, normal_z, spec_code, output ready);
endinterface

interface pptu_out_if;
  logic               valid;
  logic               ready;
  logic        [8:0]  screen_x;
  logic        [7:0]  screen_y;
  logic        [20:0] depth_value;
  logic signed [31:0] rel_x;
  logic signed [31:0] rel_y;
  logic signed [31:0] rel_z;
  logic signed [7:0]  out_normal_x;
  logic signed [7:0]  out_normal_y;
  logic signed [7:0]  out_normal_z;
  logic        [7:0]  out_spec_code;
  logic        [31:0] out_color;

  modport source (output valid, screen_x, screen_y, depth_value, rel_x, rel_y, rel_z,
                  out_normal_x, out_normal_y, out_normal_z, out_spec_code, out_color,
                  input ready);
  modport sink (input valid, screen_x, screen_y, depth_value, rel_x, rel_y, rel_z,
                out_normal_x, out_normal_y, out_normal_z, out_spec_code, out_color,
                output ready);
endinterface
`default_nettype wire

// ===== sv/pptu_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pptu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== sv/pptu_div.sv =====
// Restoring divider, one quotient bit a cycle while step is high, truncating toward zero.
// Flags quotients outside 0..lim. Depends on pptu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pptu_div (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic signed [63:0]         num,
  input  logic [pptu_pkg::DEN_W-1:0] den,
  input  logic [pptu_pkg::QBITS-1:0] lim,
  output logic [pptu_pkg::QBITS-1:0] q,
  output logic                       ok
);
  import pptu_pkg::*;

  localparam int SH_W = DEN_W + QBITS;

  logic [63:0]       rem_r;
  logic [SH_W-1:0]   dsh_r;
  logic [QBITS-1:0]  q_r;
  logic              neg_r;
  logic              big_r;
  logic [63:0]       abs_num;
  logic [63:0]       den_top;
  logic [63:0]       dsh_ext;

  assign abs_num = num[63] ? (64'd0 - 64'(num)) : 64'(num);
  assign den_top = 64'({den, {QBITS{1'b0}}});
  assign dsh_ext = 64'(dsh_r);

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= abs_num;
      dsh_r <= SH_W'({den, {(QBITS-1){1'b0}}});
      q_r   <= '0;
      neg_r <= num[63];
      big_r <= (abs_num >= den_top);
    end else if (step) begin
      if (rem_r >= dsh_ext) begin
        rem_r <= rem_r - dsh_ext;
        q_r   <= {q_r[QBITS-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QBITS-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  // a negative quotient in (-1,0) truncates to zero and stays on screen
  assign q  = q_r;
  assign ok = !big_r && !(neg_r && (q_r != '0)) && (q_r <= lim);
endmodule
`default_nettype wire

// ===== sv/pptu_ctrl.sv =====
// Sequencer for the projection unit: clear sweep, pipeline timing, divide,
// depth read/compare and output slot. Depends on pptu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pptu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_mode,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  pptu_pkg::sts_t  sts,
  output pptu_pkg::cmd_t  cmd
);
  import pptu_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = in_mode ? ST_CLR : ST_PIPE;
        end
      end
      ST_PIPE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PIPE_CYC - 1)) begin
          cnt_nxt = '0;
          if (sts.keep) begin
            cmd.div_load = 1'b1;
            state_nxt    = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QBITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // address settles this cycle, stored depth arrives next
        state_nxt = sts.div_ok ? ST_CMP : ST_IDLE;
      end
      ST_CMP: begin
        if (!sts.win) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          cmd.pix_we    = 1'b1;
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// ===== sv/pptu_dp.sv =====
// Datapath: camera registers, cull dot product, yaw/pitch rotation, depth,
// screen sums, two dividers, depth store port and output word.
// Depends on pptu_pkg, pptu_div, pptu_ram.
`timescale 1ns / 1ps
`default_nettype none
module pptu_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pptu_pkg::cmd_t                    cmd,
  output pptu_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [pptu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pptu_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [31:0]                point_x,
  input  logic signed [31:0]                point_y,
  input  logic signed [31:0]                point_z,
  input  logic        [31:0]                point_color,
  input  logic signed [7:0]                 normal_x,
  input  logic signed [7:0]                 normal_y,
  input  logic signed [7:0]                 normal_z,
  input  logic        [7:0]                 spec_code,
  output logic        [8:0]                 screen_x,
  output logic        [7:0]                 screen_y,
  output logic        [20:0]                depth_value,
  output logic signed [31:0]                rel_x,
  output logic signed [31:0]                rel_y,
  output logic signed [31:0]                rel_z,
  output logic signed [7:0]                 out_normal_x,
  output logic signed [7:0]                 out_normal_y,
  output logic signed [7:0]                 out_normal_z,
  output logic        [7:0]                 out_spec_code,
  output logic        [31:0]                out_color
);
  import pptu_pkg::*;

  // configuration
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [15:0] yc_r, ys_r, pc_r, ps_r;
  logic        [11:0] foc_r;
  logic signed [12:0] foc_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      yc_r    <= 16'sd16384;
      ys_r    <= '0;
      pc_r    <= 16'sd16384;
      ps_r    <= '0;
      foc_r   <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CAMERA_X:  cam_x_r <= $signed(cfg_data);
        CFG_CAMERA_Y:  cam_y_r <= $signed(cfg_data);
        CFG_CAMERA_Z:  cam_z_r <= $signed(cfg_data);
        CFG_YAW_COS:   yc_r    <= $signed(cfg_data[15:0]);
        CFG_YAW_SIN:   ys_r    <= $signed(cfg_data[15:0]);
        CFG_PITCH_COS: pc_r    <= $signed(cfg_data[15:0]);
        CFG_PITCH_SIN: ps_r    <= $signed(cfg_data[15:0]);
        CFG_FOCAL:     foc_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign foc_s = $signed({1'b0, foc_r});

  // captured point
  logic signed [31:0] tx_r, ty_r, tz_r;
  logic signed [7:0]  nx_r, ny_r, nz_r;
  logic        [7:0]  spec_r;
  logic        [31:0] col_r;
  logic signed [31:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      tx_r   <= point_x - cam_x_r;
      ty_r   <= point_y - cam_y_r;
      tz_r   <= point_z - cam_z_r;
      nx_r   <= normal_x;
      ny_r   <= normal_y;
      nz_r   <= normal_z;
      spec_r <= spec_code;
      col_r  <= point_color;
    end
  end

  assign dx = 32'sd0 - tx_r;
  assign dy = 32'sd0 - ty_r;
  assign dz = 32'sd0 - tz_r;

  // free-running stages; the sequencer waits until each has settled
  logic signed [39:0] pdx_r, pdy_r, pdz_r;
  logic signed [47:0] txyc_r, tzys_r, tzyc_r, txys_r, typc_r, typs_r;
  logic signed [41:0] dot_r;
  logic signed [48:0] x1_r, z0_r;
  logic signed [63:0] z0ps_r, z0pc_r, x1f_r;
  logic signed [63:0] y28_r, z28_r;
  logic [DEPTH_W-1:0] depth_r;
  logic signed [49:0] y1_r;
  logic               rng_ok_r;
  logic signed [63:0] y1f_r, numx_r, numy_r;
  logic [DEN_W-1:0]   den_r;
  logic [43:0]        z_q8;

  assign z_q8 = z28_r[63:20];

  always_ff @(posedge clk) begin
    pdx_r  <= 40'(dx) * 40'(nx_r);
    pdy_r  <= 40'(dy) * 40'(ny_r);
    pdz_r  <= 40'(dz) * 40'(nz_r);
    txyc_r <= 48'(tx_r) * 48'(yc_r);
    tzys_r <= 48'(tz_r) * 48'(ys_r);
    tzyc_r <= 48'(tz_r) * 48'(yc_r);
    txys_r <= 48'(tx_r) * 48'(ys_r);
    typc_r <= 48'(ty_r) * 48'(pc_r);
    typs_r <= 48'(ty_r) * 48'(ps_r);

    dot_r  <= 42'(pdx_r) + 42'(pdy_r) + 42'(pdz_r);
    x1_r   <= 49'(txyc_r) + 49'(tzys_r);
    z0_r   <= 49'(tzyc_r) - 49'(txys_r);

    z0ps_r <= 64'(z0_r) * 64'(ps_r);
    z0pc_r <= 64'(z0_r) * 64'(pc_r);
    x1f_r  <= 64'(x1_r) * 64'(foc_s);

    y28_r  <= (64'(typc_r) <<< 14) - z0ps_r;
    z28_r  <= (64'(typs_r) <<< 14) + z0pc_r;

    rng_ok_r <= !z28_r[63] && (z_q8 >= 44'(NEAR_Q8)) && (z_q8 <= 44'(FAR_Q8));
    depth_r  <= z28_r[20 +: DEPTH_W];
    y1_r     <= y28_r[63:14];

    y1f_r  <= 64'(y1_r) * 64'(foc_s);
    den_r  <= {depth_r, 6'b0};
    numx_r <= x1f_r + $signed(64'(den_r) * 64'(HALF_W));

    numy_r <= y1f_r + $signed(64'(den_r) * 64'(HALF_H));
  end

  // screen dividers
  logic [QBITS-1:0] qx, qy;
  logic             okx, oky;

  pptu_div u_divx (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .num  (numx_r),
    .den  (den_r),
    .lim  (QBITS'(SCREEN_WIDTH - 1)),
    .q    (qx),
    .ok   (okx)
  );

  pptu_div u_divy (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .num  (numy_r),
    .den  (den_r),
    .lim  (QBITS'(SCREEN_HEIGHT - 1)),
    .q    (qy),
    .ok   (oky)
  );

  // depth store
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [ADDR_W-1:0]  waddr;
  logic [DEPTH_W-1:0] wdata;
  logic [DEPTH_W-1:0] rdata;
  logic               we;

  assign idx = ADDR_W'(qx) + ADDR_W'(qy) * ADDR_W'(SCREEN_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end else begin
      clr_addr_r <= '0;
    end
  end

  assign we    = cmd.clr_en || cmd.pix_we;
  assign waddr = cmd.clr_en ? clr_addr_r : idx;
  assign wdata = cmd.clr_en ? DEPTH_W'(FAR_Q8) : depth_r;

  pptu_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  assign sts.clr_done = cmd.clr_en && (clr_addr_r == ADDR_W'(PIXELS - 1));
  assign sts.keep     = dot_r[41] && rng_ok_r;
  assign sts.div_ok   = okx && oky;
  assign sts.win      = depth_r < rdata;

  // output word
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      screen_x      <= 9'(qx);
      screen_y      <= 8'(qy);
      depth_value   <= 21'(depth_r);
      rel_x         <= tx_r;
      rel_y         <= ty_r;
      rel_z         <= tz_r;
      out_normal_x  <= nx_r;
      out_normal_y  <= ny_r;
      out_normal_z  <= nz_r;
      out_spec_code <= spec_r;
      out_color     <= col_r;
    end
  end
endmodule
`default_nettype wire

// ===== sv/point_project_depth_test_unit.sv =====
// Point projection with back-face cull and depth test.
// A new point is taken only when the previous one is through the rotation pipeline,
// the one-bit-per-cycle screen dividers, the depth read/compare and the output slot,
// or has been culled or rejected on the way.
// Reset (synchronous, active low) and a mode 1 word sweep every entry of the depth
// store to far, one entry a cycle, with input held off.
`timescale 1ns / 1ps
`default_nettype none
module point_project_depth_test_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  pptu_in_if.sink                          in_ch,
  pptu_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [pptu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pptu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pptu_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  pptu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  pptu_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .point_x       (in_ch.point_x),
    .point_y       (in_ch.point_y),
    .point_z       (in_ch.point_z),
    .point_color   (in_ch.point_color),
    .normal_x      (in_ch.normal_x),
    .normal_y      (in_ch.normal_y),
    .normal_z      (in_ch.normal_z),
    .spec_code     (in_ch.spec_code),
    .screen_x      (out_ch.screen_x),
    .screen_y      (out_ch.screen_y),
    .depth_value   (out_ch.depth_value),
    .rel_x         (out_ch.rel_x),
    .rel_y         (out_ch.rel_y),
    .rel_z         (out_ch.rel_z),
    .out_normal_x  (out_ch.out_normal_x),
    .out_normal_y  (out_ch.out_normal_y),
    .out_normal_z  (out_ch.out_normal_z),
    .out_spec_code (out_ch.out_spec_code),
    .out_color     (out_ch.out_color)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
endmodule
`default_nettype wire

// ===== sv/pptu_checker.sv =====
// Port-level checks for the projection unit, bound to the top level.
// Depends on pptu_pkg and point_project_depth_test_unit.
`timescale 1ns / 1ps
`default_nettype none
module pptu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [8:0]  out_screen_x,
  input logic [7:0]  out_screen_y,
  input logic [20:0] out_depth
);
  import pptu_pkg::*;

  // stalled result word holds its depth and screen x
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_depth) && $stable(out_screen_x))
    else $error("result word changed while stalled");

  // depth store sweep follows reset
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during reset sweep");

  // clear word starts a sweep
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("input taken right after clear word");

  // pixel writes stay on screen
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_screen_x < 9'(SCREEN_WIDTH)) && (out_screen_y < 8'(SCREEN_HEIGHT)))
    else $error("pixel write off screen");
endmodule

bind point_project_depth_test_unit pptu_checker u_pptu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_mode      (in_ch.mode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_screen_x (out_ch.screen_x),
  .out_screen_y (out_ch.screen_y),
  .out_depth    (out_ch.depth_value)
);
`default_nettype wire
